/* hdl/pgu_pkg.sv */
// shared types and constants of the packed group unpacker
`default_nettype none

package pgu_pkg;

  // seed bytes that follow every filler header
  localparam logic [6:0] SEED_BYTES = 7'd68;

  // target size after reset
  localparam logic [31:0] TARGET_RESET = 32'd32768;

  // result queue depth, must leave room for two items per input
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // result kinds
  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ZERO    = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  // one byte of the inflated group stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_t;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [31:0] run_length;
    logic        end_marker;
    logic        bad_group;
  } out_t;

  // up to two results written into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    out_t       item0;
    out_t       item1;
  } push_t;

endpackage

`default_nettype wire

/* hdl/packed_group_unpacker.sv */
// packed group unpacker: header parsing, seed skip, literal pass and padding
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid_i/stall_o | in_item_i  (data_byte, is_last)
//   out     | output    | out_valid_o/stall_i| out_item_o (kind .. bad_group)
//   cfg     | input     | cfg_valid_i/ready_o| cfg_data_i (target_size)
//
// one input byte is taken per cycle while not stalled; its results enter the queue
// at that same edge and are offered from the next cycle; a byte yields at most two
// results and the queue drains one item per cycle while out_stall_i is low, so the
// rate is one byte per cycle while bytes yield at most one result
// input stalls whenever the queue has fewer than two free slots
// reset clears the group state and sets target_size to 32768; cfg is always ready
`default_nettype none

module packed_group_unpacker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire pgu_pkg::in_t  in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output pgu_pkg::out_t      out_item_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [31:0]   cfg_data_i
);
  import pgu_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_SEED    = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  logic [31:0] target_q;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] shift_q, shift_d;
  logic [1:0]  hcount_q, hcount_d;
  logic [6:0]  seed_q, seed_d;
  logic [30:0] run_left_q, run_left_d;
  logic [31:0] produced_q, produced_d;

  logic        accept;
  logic        room;
  push_t       push;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = !room;
  assign cfg_ready_o = 1'b1;

  // per-byte state update and result building
  always_comb begin
    logic        owing;
    logic [31:0] hdr;
    logic [31:0] owed;
    logic [31:0] len32;
    logic        fill_short;
    logic [31:0] owed_left;
    logic [31:0] run;
    logic [31:0] pad;
    logic [6:0]  seed_inc;
    logic        main_valid;
    out_t        main_item;
    out_t        end_item;
    logic        bad;

    phase_d    = phase_q;
    shift_d    = shift_q;
    hcount_d   = hcount_q;
    seed_d     = seed_q;
    run_left_d = run_left_q;
    produced_d = produced_q;
    main_valid = 1'b0;
    main_item  = '{kind: KIND_LITERAL, out_byte: 8'd0, run_length: 32'd0,
                   end_marker: 1'b0, bad_group: 1'b0};
    end_item   = main_item;
    owing      = (produced_q < target_q);
    hdr        = {shift_q[23:0], in_item_i.data_byte};
    owed       = target_q - produced_q;
    len32      = {1'b0, hdr[30:0]};
    fill_short = (len32 < owed);
    owed_left  = owed - len32;
    seed_inc   = seed_q + 7'd1;
    run        = fill_short ? len32 : owed;
    // padding still owed after this byte, built beside the state update
    pad        = owed;
    bad        = 1'b0;

    case (phase_q)
      PH_SEED: begin
        seed_d = seed_inc;
        if (seed_inc >= SEED_BYTES) begin
          seed_d  = 7'd0;
          phase_d = PH_HEADER;
        end
      end
      PH_LITERAL: begin
        if (owing) begin
          main_valid         = 1'b1;
          main_item.out_byte = in_item_i.data_byte;
          produced_d         = produced_q + 32'd1;
          pad                = owed - 32'd1;
        end
        run_left_d = run_left_q - 31'd1;
        if (run_left_d == 31'd0) begin
          phase_d = PH_HEADER;
        end
      end
      default: begin
        // header gathering, ignored once the group is satisfied
        if (owing) begin
          shift_d  = hdr;
          hcount_d = hcount_q + 2'd1;
          if (hcount_q == 2'd3) begin
            shift_d = 32'd0;
            if (hdr[31]) begin
              produced_d           = produced_q + run;
              pad                  = fill_short ? owed_left : 32'd0;
              main_valid           = 1'b1;
              main_item.kind       = KIND_ZERO;
              main_item.run_length = run;
              seed_d               = 7'd0;
              phase_d              = PH_SEED;
            end else if (hdr[30:0] != 31'd0) begin
              run_left_d = hdr[30:0];
              phase_d    = PH_LITERAL;
            end else begin
              phase_d = PH_HEADER;
            end
          end
        end
      end
    endcase

    // end of group item, then back to a fresh group
    bad                 = (phase_d == PH_LITERAL) && (run_left_d != 31'd0);
    end_item.kind       = KIND_END;
    end_item.run_length = bad ? 32'd0 : pad;
    end_item.end_marker = 1'b1;
    end_item.bad_group  = bad;

    push.count = 2'd0;
    push.item0 = main_item;
    push.item1 = end_item;
    if (accept) begin
      if (main_valid && in_item_i.is_last) begin
        push.count = 2'd2;
      end else if (main_valid) begin
        push.count = 2'd1;
      end else if (in_item_i.is_last) begin
        push.count = 2'd1;
        push.item0 = end_item;
      end
    end

    if (in_item_i.is_last) begin
      phase_d    = PH_HEADER;
      shift_d    = 32'd0;
      hcount_d   = 2'd0;
      seed_d     = 7'd0;
      run_left_d = 31'd0;
      produced_d = 32'd0;
    end
  end

  // group state and target size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TARGET_RESET;
      phase_q    <= PH_HEADER;
      shift_q    <= 32'd0;
      hcount_q   <= 2'd0;
      seed_q     <= 7'd0;
      run_left_q <= 31'd0;
      produced_q <= 32'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q    <= phase_d;
        shift_q    <= shift_d;
        hcount_q   <= hcount_d;
        seed_q     <= seed_d;
        run_left_q <= run_left_d;
        produced_q <= produced_d;
      end
    end
  end

  // result queue
  pgu_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* hdl/pgu_outq.sv */
// result queue: takes up to two items per cycle, hands out one per cycle unless stalled
`default_nettype none

module pgu_outq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pgu_pkg::push_t push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output pgu_pkg::out_t      out_item_o
);
  import pgu_pkg::*;

  out_t              entries_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic [QPTR_W-1:0] wr_next;
  logic              pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = entries_q[rd_ptr_q];
  // room for a full pair of results
  assign room_o      = (count_q <= QCNT_W'(QDEPTH - 2));
  assign wr_next     = wr_ptr_q + QPTR_W'(1);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // item storage, written only into free slots
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.item0;
    end
    if (push_i.count == 2'd2) begin
      entries_q[wr_next] <= push_i.item1;
    end
  end

endmodule

`default_nettype wire

/* hdl/pgu_checker.sv */
// port level checks of the packed group unpacker and their bind
`default_nettype none

module pgu_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          out_valid_i,
  input wire logic          out_stall_i,
  input wire pgu_pkg::out_t out_item_i
);
  import pgu_pkg::*;

  // a stalled result item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // a stalled result item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_item_i))
    else $error("result item changed while stalled");

  // literal and zero run items never close a group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.kind == KIND_LITERAL || out_item_i.kind == KIND_ZERO)
    |-> !out_item_i.end_marker && !out_item_i.bad_group)
    else $error("end or error flag on a non-end item");

  // an end item of a bad group carries no padding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.bad_group
    |-> out_item_i.end_marker && out_item_i.kind == KIND_END &&
        out_item_i.run_length == 32'd0)
    else $error("bad group flag on a malformed item");

endmodule

bind packed_group_unpacker pgu_checker u_pgu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);

`default_nettype wire

/* test/packed_group_unpacker_checker.sv */
// result checker for the packed group unpacker: predicts every result and compares it
module packed_group_unpacker_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  pgu_pkg::in_t  in_item_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  pgu_pkg::out_t out_item_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  logic [31:0]   cfg_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            results_seen_o
);
  import pgu_pkg::*;

  // where the byte walker stands inside a group
  typedef enum logic [1:0] {
    WALK_HEADER  = 2'd0,
    WALK_SEED    = 2'd1,
    WALK_LITERAL = 2'd2
  } walk_e;

  // predicted block state
  logic [31:0] target_size;
  walk_e       walk;
  logic [31:0] hdr_shift;
  int          hdr_cnt;
  logic [6:0]  seed_cnt;
  logic [30:0] lit_left;
  logic [31:0] produced;

  out_t expected_results[$];
  out_t oldest;
  int   mismatches;
  int   results_seen;

  assign fail_count_o   = mismatches;
  assign results_seen_o = results_seen;

  function automatic out_t make_result(input kind_e kind, input logic [7:0] value,
                                       input logic [31:0] run, input logic endm,
                                       input logic bad);
    out_t r;
    r.kind       = kind;
    r.out_byte   = value;
    r.run_length = run;
    r.end_marker = endm;
    r.bad_group  = bad;
    return r;
  endfunction

  // append one predicted result at the tail
  task automatic queue_result(input out_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic clear_group();
    walk      = WALK_HEADER;
    hdr_shift = '0;
    hdr_cnt   = 0;
    seed_cnt  = '0;
    lit_left  = '0;
    produced  = '0;
  endtask

  // advance the walker by one stream byte and queue what it yields
  task automatic unpack_byte(input in_t item);
    logic [30:0] len;
    logic [31:0] owed;
    logic [31:0] run;
    logic        bad;
    case (walk)
      WALK_SEED: begin
        seed_cnt = seed_cnt + 7'd1;
        if (seed_cnt >= SEED_BYTES) begin
          seed_cnt = '0;
          walk     = WALK_HEADER;
        end
      end
      WALK_LITERAL: begin
        // literals past the target size are dropped
        if (produced < target_size) begin
          queue_result(make_result(KIND_LITERAL, item.data_byte, 32'd0, 1'b0, 1'b0));
          produced = produced + 32'd1;
        end
        lit_left = lit_left - 31'd1;
        if (lit_left == '0) walk = WALK_HEADER;
      end
      default: begin
        // header bytes only count while the group still owes bytes
        if (produced < target_size) begin
          hdr_shift = {hdr_shift[23:0], item.data_byte};
          hdr_cnt   = hdr_cnt + 1;
          if (hdr_cnt >= 4) begin
            len     = hdr_shift[30:0];
            hdr_cnt = 0;
            if (hdr_shift[31]) begin
              // filler: one clamped zero run, then the seed
              owed     = target_size - produced;
              run      = ({1'b0, len} < owed) ? {1'b0, len} : owed;
              produced = produced + run;
              queue_result(make_result(KIND_ZERO, 8'd0, run, 1'b0, 1'b0));
              seed_cnt = '0;
              walk     = WALK_SEED;
            end else if (len != '0) begin
              lit_left = len;
              walk     = WALK_LITERAL;
            end else begin
              walk = WALK_HEADER;
            end
            hdr_shift = '0;
          end
        end
      end
    endcase

    // end of group: padding, or the error flag for a cut literal run
    if (item.is_last) begin
      bad = (walk == WALK_LITERAL) && (lit_left != '0);
      queue_result(make_result(KIND_END, 8'd0, bad ? 32'd0 : target_size - produced,
                               1'b1, bad));
      clear_group();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      mismatches++;
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_size = TARGET_RESET;
      clear_group();
      expected_results.delete();
      mismatches   = 0;
      results_seen = 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item with no expected result waiting (kind %0d)",
                 out_item_i.kind);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("kind", 32'(oldest.kind), 32'(out_item_i.kind));
          check_field("out_byte", 32'(oldest.out_byte), 32'(out_item_i.out_byte));
          check_field("run_length", oldest.run_length, out_item_i.run_length);
          check_field("end_marker", 32'(oldest.end_marker), 32'(out_item_i.end_marker));
          check_field("bad_group", 32'(oldest.bad_group), 32'(out_item_i.bad_group));
        end
      end
      if (in_valid_i && !in_stall_i) unpack_byte(in_item_i);
      if (cfg_valid_i && cfg_ready_i) target_size = cfg_data_i;
      pending_o <= expected_results.size();
    end
  end

endmodule

/* test/packed_group_unpacker_tb.sv */
// testbench top for the packed group unpacker: stimulus, stalls and verdict
module packed_group_unpacker_tb;
  import pgu_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_item;
  logic        out_valid;
  logic        out_stall;
  out_t        out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        hold_req;

  int fail_count;
  int pending;
  int results_seen;
  int burst_left;
  int bytes_sent;
  int groups_sent;
  int targets_used;

  logic [7:0] group_bytes[$];

  packed_group_unpacker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  packed_group_unpacker_checker result_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_item_i      (in_item),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_item_i     (out_item),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #800000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int  mode;
    int  seg;
    logic hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 120);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          out_stall <= 1'b1;
          repeat (150) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // one stream byte, with bursts and random gaps on the sending side
  task automatic send_byte(input logic [7:0] value, input logic last);
    int   gap;
    logic st;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid          <= 1'b1;
    in_item.data_byte <= value;
    in_item.is_last   <= last;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_group();
    int k;
    for (k = 0; k < group_bytes.size(); k++)
      send_byte(group_bytes[k], k == group_bytes.size() - 1);
    group_bytes.delete();
    groups_sent++;
  endtask

  // append one byte to the group being built
  task automatic add_byte(input logic [7:0] value);
    group_bytes.insert(group_bytes.size(), value);
  endtask

  task automatic add_header(input logic filler, input logic [30:0] len);
    logic [31:0] word;
    word = {filler, len};
    add_byte(word[31:24]);
    add_byte(word[23:16]);
    add_byte(word[15:8]);
    add_byte(word[7:0]);
  endtask

  task automatic add_noise(input int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  // block idle: no result owed, then a settle wait for bytes that yield nothing
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int          ph;
    int          start;
    int          n_ent;
    int          k;
    int          pick;
    int          len;
    logic        stop;
    logic        rdy;
    logic [30:0] len31;
    logic [31:0] tgt;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    hold_req     = 1'b0;
    burst_left   = 0;
    bytes_sent   = 0;
    groups_sent  = 0;
    targets_used = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: literal extremes, empty literal, oversized filler cut in its seed
    add_header(1'b0, 31'd2);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_header(1'b0, 31'd0);
    add_header(1'b1, 31'h7FFF_FFFF);
    add_byte(8'hA5);
    send_group();
    // literal run cut short by the last byte
    add_header(1'b0, 31'd5);
    add_byte(8'h5A);
    send_group();
    // group ending inside its header
    add_byte(8'h80);
    send_group();

    // random groups over several target sizes
    for (ph = 0; ph < 9; ph++) begin
      if (ph != 0) begin
        case (ph)
          1: tgt = 32'd1;
          2: tgt = 32'hFFFF_FFFF;
          3: tgt = $urandom_range(1, 20);
          4: tgt = $urandom_range(2, 300);
          5: do tgt = $urandom; while (tgt == 32'd0);
          6: tgt = 32'd2;
          7: tgt = $urandom_range(1, 60);
          default: tgt = $urandom_range(300, 5000);
        endcase
        wait_drained(8);
        cfg_valid <= 1'b1;
        cfg_data  <= tgt;
        do begin
          @(negedge clk);
          rdy = cfg_ready;
          @(posedge clk);
        end while (!rdy);
        cfg_valid <= 1'b0;
        targets_used++;
      end
      if (ph == 2) hold_req <= 1'b1;
      start = bytes_sent;
      while (bytes_sent - start < 70) begin
        if ($urandom_range(0, 9) == 0) begin
          // pure noise: random headers of any kind
          add_noise($urandom_range(1, 12));
        end else begin
          stop  = 1'b0;
          n_ent = $urandom_range(1, 5);
          for (k = 0; k < n_ent && !stop; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 13) begin
              // filler entry with its seed, sometimes cut short
              case ($urandom_range(0, 3))
                0: len31 = '0;
                1: len31 = 31'($urandom_range(1, 50));
                2: len31 = 31'($urandom);
                default: len31 = 31'($urandom_range(1, 4000));
              endcase
              add_header(1'b1, len31);
              if ($urandom_range(0, 9) == 0) begin
                add_noise($urandom_range(0, 67));
                stop = 1'b1;
              end else begin
                add_noise(SEED_BYTES);
              end
            end else if (pick < 90) begin
              // literal entry
              case ($urandom_range(0, 9))
                7, 8: len = $urandom_range(11, 40);
                9: len = -1;
                default: len = $urandom_range(0, 10);
              endcase
              if (len < 0) begin
                // huge run that the group can never finish
                add_header(1'b0, 31'($urandom));
                add_noise($urandom_range(0, 6));
                stop = 1'b1;
              end else begin
                add_header(1'b0, 31'(len));
                add_noise(len);
              end
            end else begin
              // partial header at the end of the group
              add_noise($urandom_range(1, 3));
              stop = 1'b1;
            end
          end
          if (group_bytes.size() == 0) add_noise(1);
        end
        send_group();
      end
    end

    wait_drained(20);
    $display("sent %0d stream bytes in %0d groups under %0d target sizes",
             bytes_sent, groups_sent, targets_used);
    $display("compared %0d result items, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
